// ===== rtl/core/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types and constants for the frame parser, the command queue and
// the result stage.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Status codes carried on frame_status.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StClose = 2'd1;
  localparam logic [1:0] StIgn   = 2'd2;
  localparam logic [1:0] StErr   = 2'd3;

  // Opcodes of the first header byte.
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;

  // Header bit fields.
  localparam logic [7:0] HdrRsvMask = 8'h70;
  localparam logic [7:0] HdrFinMask = 8'h80;
  localparam logic [7:0] MaskBit    = 8'h80;
  localparam logic [6:0] Len16Code  = 7'h7e;
  localparam logic [6:0] Len64Code  = 7'h7f;

  // Command queue geometry.
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // One classified command from the parser to the result stage.
  typedef struct packed {
    logic       is_status;
    logic [1:0] status;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
  } cmd_t;

  // Queue status seen by its neighbors.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// ===== rtl/core/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses client frames one byte at a time and returns unmasked payload
// bytes or a single status per frame.
//
//   Channel  | Handshake        | Fields
//   ---------+------------------+-------------------------------------------
//   input    | push_i / full_o  | data_byte_i, frame_start_i
//   result   | pop_i  / empty_o | result_kind_o, payload_byte_o,
//            |                  | frame_status_o, last_of_frame_o
//
// One byte is taken each cycle while full_o is low; the parser state update
// and the key-byte select fit in that cycle. A result passes through the
// command queue and the output register before it appears.
// Reset clears the parser to idle and empties the queue and output slot.
// A stalled result side fills the four-entry queue, then raises full_o.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_start_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic       result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [1:0] frame_status_o,
  output logic       last_of_frame_o
);
  import wsd_pkg::*;

  logic    accept;
  logic    cmd_valid;
  cmd_t    front_cmd;
  cmd_t    q_cmd;
  q_stat_t q_stat;
  logic    cmd_rd;

  // Input transfer.
  assign full_o = q_stat.full;
  assign accept = push_i && !q_stat.full;

  wsd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (front_cmd)
  );

  wsd_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (cmd_valid),
    .wr_cmd_i (front_cmd),
    .rd_i     (cmd_rd),
    .rd_cmd_o (q_cmd),
    .stat_o   (q_stat)
  );

  wsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .cmd_i           (q_cmd),
    .cmd_rd_o        (cmd_rd),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .result_kind_o   (result_kind_o),
    .payload_byte_o  (payload_byte_o),
    .frame_status_o  (frame_status_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

// ===== rtl/core/wsd_front.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Parses the frame header, collects the masking key and classifies each
// byte into a command for the result stage.
// ----------------------------------------------------------------------------
module wsd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          frame_start_i,
  output logic          cmd_valid_o,
  output wsd_pkg::cmd_t cmd_o
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PhIdle, PhHdr1, PhLenHi, PhLenLo, PhKey, PhPayload
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr0_q, hdr0_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  cnt_q, cnt_d;

  logic [3:0]  op;
  logic [6:0]  len7;
  logic        bad;
  logic [15:0] len_full;
  logic        emit;
  cmd_t        cmd;

  assign op       = hdr0_q[3:0];
  assign len7     = data_byte_i[6:0];
  assign bad      = ((hdr0_q & HdrRsvMask) != 8'h00) || ((hdr0_q & HdrFinMask) == 8'h00) ||
                    ((data_byte_i & MaskBit) == 8'h00);
  assign len_full = rem_q | {8'h00, data_byte_i};

  // Next-state and command classification for one accepted byte.
  always_comb begin
    phase_d       = phase_q;
    hdr0_d        = hdr0_q;
    rem_d         = rem_q;
    key_d         = key_q;
    cnt_d         = cnt_q;
    emit          = 1'b0;
    cmd.is_status = 1'b1;
    cmd.status    = StErr;
    cmd.data      = data_byte_i;
    cmd.key       = key_q[{~cnt_q, 3'b000} +: 8];
    cmd.last      = 1'b1;
    if (frame_start_i) begin
      // A start inside an open frame closes the old frame with an error.
      emit    = (phase_q != PhIdle);
      hdr0_d  = data_byte_i;
      rem_d   = '0;
      key_d   = '0;
      cnt_d   = '0;
      phase_d = PhHdr1;
    end else begin
      case (phase_q)
        PhHdr1: begin
          emit    = 1'b1;
          phase_d = PhIdle;
          if (op == OpText) begin
            if (bad || len7 == Len64Code) begin
              cmd.status = StErr;
            end else if (len7 == Len16Code) begin
              emit    = 1'b0;
              phase_d = PhLenHi;
            end else if (len7 == 7'd0) begin
              cmd.status = StOk;
            end else begin
              emit    = 1'b0;
              rem_d   = {9'd0, len7};
              cnt_d   = '0;
              phase_d = PhKey;
            end
          end else if (bad) begin
            cmd.status = StErr;
          end else if (op inside {OpBinary, OpPing, OpPong}) begin
            cmd.status = StIgn;
          end else if (op == OpClose) begin
            cmd.status = StClose;
          end else begin
            cmd.status = StErr;
          end
        end
        PhLenHi: begin
          rem_d   = {data_byte_i, 8'h00};
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          rem_d = len_full;
          if (len_full == 16'd0) begin
            // An empty text frame finishes on its length.
            emit       = 1'b1;
            cmd.status = StOk;
            phase_d    = PhIdle;
          end else begin
            cnt_d   = '0;
            phase_d = PhKey;
          end
        end
        PhKey: begin
          key_d = {key_q[23:0], data_byte_i};
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          emit          = 1'b1;
          cmd.is_status = 1'b0;
          cmd.status    = StOk;
          cmd.last      = (rem_q <= 16'd1);
          cnt_d         = cnt_q + 2'd1;
          if (rem_q != 16'd0) begin
            rem_d = rem_q - 16'd1;
          end
          if (rem_q <= 16'd1) begin
            phase_d = PhIdle;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  assign cmd_valid_o = accept_i && emit;
  assign cmd_o       = cmd;

  // Parser state, updated on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      hdr0_q  <= '0;
      rem_q   <= '0;
      key_q   <= '0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hdr0_q  <= hdr0_d;
      rem_q   <= rem_d;
      key_q   <= key_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/wsd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer command queue
// A short queue of classified commands between the parser and the result
// stage, so each side can stall on its own.
// ----------------------------------------------------------------------------
module wsd_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  wsd_pkg::cmd_t    wr_cmd_i,
  input  logic             rd_i,
  output wsd_pkg::cmd_t    rd_cmd_o,
  output wsd_pkg::q_stat_t stat_o
);
  import wsd_pkg::*;

  cmd_t               entry_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q;
  logic [CmdPtrW-1:0] rd_ptr_q;
  logic [CmdCntW-1:0] count_q;
  logic               do_wr;
  logic               do_rd;

  assign stat_o.full      = (count_q == CmdCntW'(CmdDepth));
  assign stat_o.not_empty = (count_q != '0);
  assign do_wr            = wr_i && !stat_o.full;
  assign do_rd            = rd_i && stat_o.not_empty;
  assign rd_cmd_o         = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + CmdPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + CmdPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CmdCntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CmdCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/wsd_back.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer result stage
// Takes commands from the queue, unmasks payload bytes and holds the
// result in an output register until it is popped.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wsd_pkg::q_stat_t q_stat_i,
  input  wsd_pkg::cmd_t    cmd_i,
  output logic             cmd_rd_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             result_kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [1:0]       frame_status_o,
  output logic             last_of_frame_o
);
  import wsd_pkg::*;

  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] payload_q;
  logic [1:0] status_q;
  logic       last_q;
  logic       take;

  // Load a new command whenever the output slot is free or being emptied.
  assign take     = q_stat_i.not_empty && (!out_valid_q || pop_i);
  assign cmd_rd_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: unmask data bytes, zero the byte of a status result.
  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q    <= cmd_i.is_status;
      payload_q <= cmd_i.is_status ? 8'h00 : (cmd_i.data ^ cmd_i.key);
      status_q  <= cmd_i.status;
      last_q    <= cmd_i.last;
    end
  end

  assign empty_o         = !out_valid_q;
  assign result_kind_o   = kind_q;
  assign payload_byte_o  = payload_q;
  assign frame_status_o  = status_q;
  assign last_of_frame_o = last_q;

endmodule

// ===== tb/sv/websocket_frame_deframer_top_tb.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Streams directed and random client frames into the deframer byte by byte,
// predicts every unmasked payload byte and frame status, and compares each
// result transfer in order against the prediction.
// ----------------------------------------------------------------------------

// Parser phases of the predictor.
typedef enum logic [2:0] {
  PhIdle,
  PhHdr1,
  PhLenHi,
  PhLenLo,
  PhKey,
  PhPayload
} parse_phase_e;

// One result transfer as seen on the output ports.
typedef struct packed {
  logic       kind;
  logic [7:0] payload;
  logic [1:0] status;
  logic       last;
} deframed_t;

// Tracks the frame parse of accepted bytes and checks the results in order.
class deframe_scoreboard;
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  parse_phase_e phase;
  logic [7:0]   hdr0;
  logic [15:0]  remaining;
  logic [31:0]  mask_key;
  logic [1:0]   key_idx;
  deframed_t    expected_q[$];
  int           errors;
  int           bytes_taken;

  function new();
    phase       = PhIdle;
    hdr0        = 8'h00;
    remaining   = 16'h0000;
    mask_key    = 32'h0;
    key_idx     = 2'd0;
    errors      = 0;
    bytes_taken = 0;
  endfunction

  // A status-only result always closes the frame.
  function void finish_frame(logic [1:0] status);
    deframed_t r;
    r.kind    = KindStatus;
    r.payload = 8'h00;
    r.status  = status;
    r.last    = 1'b1;
    expected_q.push_back(r);
    phase = PhIdle;
  endfunction

  // The second header byte decides the whole frame.
  function void classify(logic [7:0] b);
    logic [3:0] op;
    logic [6:0] len7;
    logic       bad;
    op   = hdr0[3:0];
    len7 = b[6:0];
    bad  = ((hdr0 & wsd_pkg::HdrRsvMask) != 8'h00) ||
           ((hdr0 & wsd_pkg::HdrFinMask) == 8'h00) ||
           ((b & wsd_pkg::MaskBit) == 8'h00);
    if (op == wsd_pkg::OpText) begin
      if (bad || len7 == wsd_pkg::Len64Code) begin
        finish_frame(wsd_pkg::StErr);
      end else if (len7 == wsd_pkg::Len16Code) begin
        phase = PhLenHi;
      end else if (len7 == 7'd0) begin
        finish_frame(wsd_pkg::StOk);
      end else begin
        remaining = {9'd0, len7};
        key_idx   = 2'd0;
        phase     = PhKey;
      end
    end else if (bad) begin
      finish_frame(wsd_pkg::StErr);
    end else if (op == wsd_pkg::OpBinary || op == wsd_pkg::OpPing ||
                 op == wsd_pkg::OpPong) begin
      finish_frame(wsd_pkg::StIgn);
    end else if (op == wsd_pkg::OpClose) begin
      finish_frame(wsd_pkg::StClose);
    end else begin
      finish_frame(wsd_pkg::StErr);
    end
  endfunction

  // Notes one accepted input transfer and queues the result it causes.
  function void note_byte(logic [7:0] b, logic start);
    deframed_t  r;
    logic [7:0] k;
    if (start || phase != PhIdle) bytes_taken++;
    if (start) begin
      // A new frame start abandons any frame still being parsed.
      if (phase != PhIdle) finish_frame(wsd_pkg::StErr);
      hdr0      = b;
      remaining = 16'h0000;
      mask_key  = 32'h0;
      key_idx   = 2'd0;
      phase     = PhHdr1;
    end else begin
      case (phase)
        PhHdr1: classify(b);
        PhLenHi: begin
          remaining = {b, 8'h00};
          phase     = PhLenLo;
        end
        PhLenLo: begin
          remaining = {remaining[15:8], b};
          if (remaining == 16'h0000) begin
            finish_frame(wsd_pkg::StOk);
          end else begin
            key_idx = 2'd0;
            phase   = PhKey;
          end
        end
        PhKey: begin
          mask_key = {mask_key[23:0], b};
          key_idx  = key_idx + 2'd1;
          if (key_idx == 2'd0) phase = PhPayload;
        end
        PhPayload: begin
          k         = mask_key[(3 - key_idx) * 8 +: 8];
          r.kind    = KindPayload;
          r.payload = b ^ k;
          r.status  = wsd_pkg::StOk;
          r.last    = (remaining <= 16'd1);
          expected_q.push_back(r);
          key_idx = key_idx + 2'd1;
          if (remaining != 16'h0000) remaining = remaining - 16'd1;
          if (r.last) phase = PhIdle;
        end
        default: phase = PhIdle;
      endcase
    end
  endfunction

  function void compare(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Checks one result transfer against the oldest expectation.
  function void check_result(logic kind, logic [7:0] payload, logic [1:0] status,
                             logic last);
    deframed_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: extra result, expected none, actual kind %0d byte 'h%0h st %0d last %0d",
               $time, kind, payload, status, last);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    compare("result_kind", e.kind, kind);
    compare("payload_byte", e.payload, payload);
    compare("frame_status", e.status, status);
    compare("last_of_frame", e.last, last);
  endfunction
endclass

module websocket_frame_deframer_top_tb;

  logic       clk_i;
  logic       rst_ni;
  logic       push_i;
  logic       full_o;
  logic [7:0] data_byte_i;
  logic       frame_start_i;
  logic       empty_o;
  logic       pop_i;
  logic       result_kind_o;
  logic [7:0] payload_byte_o;
  logic [1:0] frame_status_o;
  logic       last_of_frame_o;

  deframe_scoreboard sb = new();
  bit hold_request;
  bit tx_quiet;

  // Directed bytes, bit 8 is the frame start flag.
  logic [8:0] directed_seq [27] = '{
    9'h0ff,                          // idle byte outside a frame
    9'h188, 9'h080,                  // close
    9'h182, 9'h080,                  // binary, ignored
    9'h189, 9'h080,                  // ping, ignored
    9'h18a, 9'h080,                  // pong, ignored
    9'h101, 9'h081,                  // text with FIN clear
    9'h1f8, 9'h080,                  // close with RSV bits set
    9'h183, 9'h000,                  // unknown opcode, mask clear
    9'h181, 9'h0ff,                  // 64-bit length
    9'h181, 9'h0fe, 9'h000, 9'h000,  // 16-bit length of zero
    9'h181, 9'h082, 9'h0aa, 9'h055,  // abandoned inside the key
    9'h181, 9'h080                   // empty text frame
  };

  websocket_frame_deframer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .data_byte_i    (data_byte_i),
    .frame_start_i  (frame_start_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_status_o (frame_status_o),
    .last_of_frame_o(last_of_frame_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random byte that hits the extremes often.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offers one byte and waits for its input transfer.
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (!tx_quiet && $urandom_range(99) < 10) begin
      push_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    push_i        <= 1'b1;
    data_byte_i   <= b;
    frame_start_i <= start;
    do @(posedge clk_i); while (full_o);
    sb.note_byte(b, start);
  endtask

  // Header bytes, an optional 16-bit length, then random key and body bytes.
  task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1, input bit use_ext,
                            input logic [15:0] ext_len, input int n_tail);
    send_byte(h0, 1'b1);
    send_byte(h1, 1'b0);
    if (use_ext) begin
      send_byte(ext_len[15:8], 1'b0);
      send_byte(ext_len[7:0], 1'b0);
    end
    repeat (n_tail) send_byte(rand_byte(), 1'b0);
  endtask

  // Stops offering until every predicted result has been taken.
  task automatic wait_drained();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // One random frame: mostly well-formed text, plus control, faults and noise.
  task automatic random_frame();
    int          pick;
    int          r;
    int          len;
    int          tail;
    bit          use_ext;
    logic [15:0] ext;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [3:0]  ops [4];
    ops[0] = wsd_pkg::OpClose;
    ops[1] = wsd_pkg::OpBinary;
    ops[2] = wsd_pkg::OpPing;
    ops[3] = wsd_pkg::OpPong;
    h0     = wsd_pkg::HdrFinMask | {4'h0, wsd_pkg::OpText};
    pick   = $urandom_range(99);
    if (pick < 60) begin
      use_ext = 1'b0;
      ext     = 16'h0000;
      r       = $urandom_range(19);
      if (r == 0) len = 0;
      else if (r == 1) len = 125;
      else if (r < 16) len = $urandom_range(12, 1);
      else begin
        use_ext = 1'b1;
        if (r == 19) ext = 16'($urandom_range(16'hffff));
        else if (r == 18) ext = 16'($urandom_range(300, 126));
        else ext = 16'($urandom_range(40));
        len = ext;
      end
      h1   = use_ext ? {1'b1, wsd_pkg::Len16Code} : {1'b1, len[6:0]};
      tail = 4 + len;
      // Huge lengths are cut short and left for the next start to abandon.
      if (len > 300) tail = $urandom_range(12);
      else if ($urandom_range(9) == 0) tail = tail + $urandom_range(3, 1);
      else if ($urandom_range(9) == 0) tail = $urandom_range(tail - 1);
      send_frame(h0, h1, use_ext, ext, tail);
    end else if (pick < 72) begin
      h0 = wsd_pkg::HdrFinMask | {4'h0, ops[$urandom_range(3)]};
      send_frame(h0, rand_byte() | wsd_pkg::MaskBit, 1'b0, 16'h0000, $urandom_range(6));
    end else if (pick < 87) begin
      case ($urandom_range(3))
        0: begin
          h0 = rand_byte();
          h1 = rand_byte();
        end
        1: begin
          h0 = h0 ^ (8'h01 << $urandom_range(7, 4));
          h1 = 8'h85;
        end
        2: h1 = rand_byte() & 8'h7f;
        default: h1 = {1'b1, wsd_pkg::Len64Code};
      endcase
      send_frame(h0, h1, 1'b0, 16'h0000, $urandom_range(8));
    end else if (pick < 94) begin
      repeat ($urandom_range(4, 1)) send_byte(rand_byte(), 1'b0);
    end else begin
      len = $urandom_range(20, 5);
      send_frame(h0, {1'b1, 7'(len)}, 1'b0, 16'h0000, $urandom_range(len + 3));
    end
  endtask

  // Sender: reset, directed bytes, then random frames.
  initial begin
    bit hold_done;
    bit drain_done;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    tx_quiet      = 1'b0;
    hold_request  = 1'b0;
    rst_ni        = 1'b0;
    push_i        = 1'b0;
    data_byte_i   = 8'h00;
    frame_start_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);
    wait_drained();
    while (sb.bytes_taken < 1200) begin
      if (!hold_done && sb.bytes_taken >= 300) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!drain_done && sb.bytes_taken >= 800) begin
        wait_drained();
        drain_done = 1'b1;
      end
      tx_quiet = (sb.bytes_taken >= 500 && sb.bytes_taken < 700);
      random_frame();
    end
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("websocket_frame_deframer_top test passed");
    end else begin
      $display("websocket_frame_deframer_top test failed");
    end
    $finish;
  end

  // Receiver: checks each result transfer and pops with random stalls.
  initial begin
    int hold_left;
    int cyc;
    hold_left = 0;
    cyc       = 0;
    pop_i     = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (pop_i && !empty_o) begin
        sb.check_result(result_kind_o, payload_byte_o, frame_status_o, last_of_frame_o);
      end
      if (hold_request) begin
        hold_left    = 300;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= (cyc >= 1000 && cyc < 1400) || ($urandom_range(99) >= 18);
      end
      cyc++;
      @(posedge clk_i);
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("websocket_frame_deframer_top test failed");
    $finish;
  end

endmodule
